@@ hw/rtl/gtu_pkg.sv @@
// Package with the word types and codes of the tag unpacker.
`default_nettype none

package gtu_pkg;

	typedef enum logic [2:0] {
		KIND_TAG             = 3'd0,
		KIND_WRITE           = 3'd1,
		KIND_BAD_FORMAT      = 3'd2,
		KIND_BAD_REGISTER    = 3'd3,
		KIND_DATA_BAD_FORMAT = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		FMT_PACKED = 2'd0,
		FMT_REGLIST = 2'd1,
		FMT_IMAGE = 2'd2,
		FMT_DISABLED = 2'd3
	} format_t;

	localparam logic [3:0] REG_PRIM = 4'h0;
	localparam logic [3:0] REG_AD   = 4'hE;

	localparam int XFER_W  = 19;
	localparam int LOOPS_W = 15;
	localparam int COUNT_W = 5;
	localparam int POS_W   = 4;

	typedef struct packed {
		logic [63:0] quad_high;
		logic [63:0] quad_low;
	} quad_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  target_address;
		logic [63:0] write_value;
		logic        end_of_packet;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/gtu_if.sv @@
// Valid/ready channel interfaces for the quadword input and the result output.
`default_nettype none

interface gtu_quad_if;
	import gtu_pkg::*;
	logic  valid;
	logic  ready;
	quad_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gtu_result_if;
	import gtu_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gtu_core.sv @@
// Tag state registers and the per-word decode of the packed tag stream.
`default_nettype none

module gtu_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              step,
	input  gtu_pkg::quad_t   quad,
	output gtu_pkg::result_t result
);
	import gtu_pkg::*;

	logic [XFER_W-1:0]  xfer_q, xfer_d;
	format_t            fmt_q, fmt_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [63:0]        list_q, list_d;
	logic [POS_W-1:0]   pos_q, pos_d;

	logic [LOOPS_W-1:0]         loops;
	logic [COUNT_W-1:0]         tag_count;
	logic [LOOPS_W+COUNT_W-1:0] product;
	logic [3:0]                 code;
	logic [COUNT_W-1:0]         pos_inc;

	assign loops     = quad.quad_low[LOOPS_W-1:0];
	assign tag_count = (quad.quad_low[63:60] == 4'd0) ? 5'd16 : {1'b0, quad.quad_low[63:60]};
	assign product   = {{COUNT_W{1'b0}}, loops} * {{LOOPS_W{1'b0}}, tag_count};
	assign code      = list_q[{pos_q, 2'b00} +: 4];
	assign pos_inc   = {1'b0, pos_q} + 5'd1;

	always_comb begin
		result  = '0;
		xfer_d  = xfer_q;
		fmt_d   = fmt_q;
		count_d = count_q;
		list_d  = list_q;
		pos_d   = pos_q;
		if (xfer_q == '0) begin
			// A tag word: load the new tag, the count only runs in packed format.
			result.end_of_packet = quad.quad_low[15];
			fmt_d   = format_t'(quad.quad_low[59:58]);
			list_d  = quad.quad_high;
			pos_d   = '0;
			count_d = tag_count;
			if (format_t'(quad.quad_low[59:58]) == FMT_PACKED) begin
				xfer_d             = product[XFER_W-1:0];
				result.result_kind = KIND_TAG;
			end else begin
				result.result_kind = KIND_BAD_FORMAT;
			end
		end else begin
			if (fmt_q == FMT_PACKED) begin
				case (code)
					REG_PRIM: begin
						result.result_kind = KIND_WRITE;
						result.write_value = {53'd0, quad.quad_low[10:0]};
					end
					REG_AD: begin
						result.result_kind    = KIND_WRITE;
						result.target_address = quad.quad_high[7:0];
						result.write_value    = quad.quad_low;
					end
					default: begin
						result.result_kind = KIND_BAD_REGISTER;
					end
				endcase
				pos_d = (pos_inc == count_q) ? '0 : pos_inc[POS_W-1:0];
			end else begin
				result.result_kind = KIND_DATA_BAD_FORMAT;
			end
			xfer_d = xfer_q - 19'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_q  <= '0;
			fmt_q   <= FMT_PACKED;
			count_q <= '0;
			list_q  <= '0;
			pos_q   <= '0;
		end else if (step) begin
			xfer_q  <= xfer_d;
			fmt_q   <= fmt_d;
			count_q <= count_d;
			list_q  <= list_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/giftag_packed_unpacker.sv @@
// A word accepted at the input is held in the input register; its result is loaded
// into the result register once that register is empty or being taken, then offered.
// Throughput: one word per cycle while results are taken; the input register frees whenever the result
// register is empty or being taken, so both sides run at full rate unless the result side stalls.
// Reset clears the valid flags and the tag state, so the first word is read as a tag.
`default_nettype none

module giftag_packed_unpacker (
	input  wire          clk,
	input  wire          arst_n,
	gtu_quad_if.sink     quad,
	gtu_result_if.source result
);
	import gtu_pkg::*;

	logic    valid_s1;
	quad_t   quad_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t decoded;
	logic    advance;
	logic    load_s2;

	assign advance    = !valid_s2 || result.ready;
	assign load_s2    = valid_s1 && advance;
	assign quad.ready = !valid_s1 || advance;

	gtu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load_s2),
		.quad   (quad_s1),
		.result (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (quad.ready) begin
				valid_s1 <= quad.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quad.valid && quad.ready) begin
			quad_s1 <= quad.data;
		end
		if (load_s2) begin
			result_s2 <= decoded;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	// A word waiting in the input register must not change while the result side stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(quad_s1))
		else $error("input word changed while stalled");

	// Only register writes carry an address or a value.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.result_kind != KIND_WRITE |->
		result_s2.target_address == 8'd0 && result_s2.write_value == 64'd0)
		else $error("address or value set on a non-write result");

	// A non-packed tag leaves no transfers, so data under a bad format never appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.result_kind != KIND_DATA_BAD_FORMAT)
		else $error("data word reported under an unsupported format");

	// With the result register empty the input side always takes a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> quad.ready)
		else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

@@ tb/giftag_packed_unpacker_test.sv @@
// Self-checking testbench for the packed-mode tag unpacker with random word traffic.
`timescale 1ns / 100ps

module giftag_packed_unpacker_test;
	import gtu_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int LONG_HOLD    = 150;

	logic clk = 1'b0;
	logic arst_n;

	gtu_quad_if   quad_ch();
	gtu_result_if result_ch();

	giftag_packed_unpacker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.quad   (quad_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Unpacker state as seen from the stream of accepted words.
	logic [XFER_W-1:0]  xfers_left = '0;
	format_t            cur_format = FMT_PACKED;
	logic [COUNT_W-1:0] reg_count  = '0;
	logic [63:0]        reg_list   = '0;
	logic [POS_W-1:0]   list_pos   = '0;

	result_t awaited_results[$];
	int      error_count = 0;
	int      cycle_count = 0;
	bit      src_idle_on = 1'b1;
	bit      sink_idle_on = 1'b1;
	bit      long_hold_req = 1'b0;

	function automatic result_t unpack_quad(input logic [63:0] lo, input logic [63:0] hi);
		result_t    res;
		logic [3:0] code;
		res = '{result_kind: KIND_TAG, target_address: '0, write_value: '0,
			end_of_packet: 1'b0};
		if (xfers_left == '0) begin
			reg_count  = (lo[63:60] == 4'd0) ? 5'd16 : {1'b0, lo[63:60]};
			cur_format = format_t'(lo[59:58]);
			reg_list   = hi;
			list_pos   = '0;
			res.end_of_packet = lo[15];
			if (cur_format == FMT_PACKED) begin
				xfers_left = XFER_W'(lo[14:0]) * XFER_W'(reg_count);
			end else begin
				res.result_kind = KIND_BAD_FORMAT;
			end
		end else begin
			if (cur_format == FMT_PACKED) begin
				code = reg_list[list_pos*4 +: 4];
				if (code == REG_PRIM) begin
					res.result_kind = KIND_WRITE;
					res.write_value = {53'd0, lo[10:0]};
				end else if (code == REG_AD) begin
					res.result_kind    = KIND_WRITE;
					res.target_address = hi[7:0];
					res.write_value    = lo;
				end else begin
					res.result_kind = KIND_BAD_REGISTER;
				end
				list_pos = ({1'b0, list_pos} + 5'd1 == reg_count) ? '0 : list_pos + 4'd1;
			end else begin
				res.result_kind = KIND_DATA_BAD_FORMAT;
			end
			xfers_left = xfers_left - 19'd1;
		end
		return res;
	endfunction

	function automatic logic [63:0] tag_low(input logic [14:0] loops, input logic eop,
			input format_t fmt, input logic [3:0] regs);
		logic [63:0] lo;
		// Bits 16 to 57 are ignored by the unpacker, so they carry noise.
		lo = {$urandom, $urandom};
		lo[14:0]  = loops;
		lo[15]    = eop;
		lo[59:58] = fmt;
		lo[63:60] = regs;
		return lo;
	endfunction

	task automatic send_quad(input logic [63:0] lo, input logic [63:0] hi);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			quad_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		quad_ch.valid <= 1'b1;
		quad_ch.data  <= '{quad_high: hi, quad_low: lo};
		@(posedge clk);
		while (!quad_ch.ready) @(posedge clk);
		awaited_results.push_back(unpack_quad(lo, hi));
	endtask

	task automatic wait_results_done();
		quad_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
				check_field("target_address", 64'(want.target_address),
					64'(got.target_address));
				check_field("write_value", want.write_value, got.write_value);
				check_field("end_of_packet", 64'(want.end_of_packet),
					64'(got.end_of_packet));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				awaited_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			stall = 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 9);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	task automatic test_directed();
		// Zero loop count: the next word is a tag again.
		send_quad(tag_low(15'd0, 1'b1, FMT_PACKED, 4'd1), {$urandom, $urandom});
		// Two loops over a primitive code and an address+data code.
		send_quad(tag_low(15'd2, 1'b0, FMT_PACKED, 4'd2), {56'd0, REG_AD, REG_PRIM});
		send_quad('1, '0);
		send_quad('1, '1);
		send_quad('0, '1);
		send_quad('0, '0);
		// Register count field of zero means sixteen; every code once.
		send_quad(tag_low(15'd1, 1'b1, FMT_PACKED, 4'd0), 64'hFEDCBA9876543210);
		for (int i = 0; i < 16; i++) begin
			send_quad({$urandom, $urandom}, {$urandom, $urandom});
		end
		// Non-packed tags are reported and leave no transfers pending.
		send_quad(tag_low(15'h7FFF, 1'b1, FMT_REGLIST, 4'hF), '1);
		send_quad(tag_low(15'h7FFF, 1'b0, FMT_IMAGE, 4'h0), '0);
		send_quad(tag_low(15'h7FFF, 1'b1, FMT_DISABLED, 4'h8), {$urandom, $urandom});
		send_quad(tag_low(15'd1, 1'b0, FMT_PACKED, 4'd1), 64'd0);
		send_quad({$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic test_random_stream(input int n_items);
		logic [63:0] lo;
		logic [63:0] hi;
		int          pick;
		logic [14:0] loops;
		format_t     fmt;
		repeat (n_items) begin
			if (xfers_left == '0) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)       loops = 15'd0;
				else if (pick < 85) loops = 15'($urandom_range(1, 4));
				else if (pick < 97) loops = 15'($urandom_range(5, 12));
				else                loops = 15'($urandom_range(13, 40));
				fmt = ($urandom_range(0, 9) == 0) ? format_t'($urandom_range(1, 3))
					: FMT_PACKED;
				lo = tag_low(loops, 1'($urandom), fmt, 4'($urandom));
				// Mostly known register codes so that writes dominate.
				for (int i = 0; i < 16; i++) begin
					pick = $urandom_range(0, 9);
					hi[i*4 +: 4] = (pick < 4) ? REG_PRIM : (pick < 8) ? REG_AD
						: 4'($urandom);
				end
			end else begin
				lo = {$urandom, $urandom};
				if ($urandom_range(0, 7) == 0) lo = lo >> $urandom_range(1, 63);
				hi = {$urandom, $urandom};
			end
			send_quad(lo, hi);
		end
	endtask

	task automatic test_backpressure();
		src_idle_on   = 1'b0;
		long_hold_req = 1'b1;
		test_random_stream(60);
		wait_results_done();
		src_idle_on = 1'b1;
	endtask

	task automatic test_clean_tail();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		test_random_stream(250);
	endtask

	initial begin
		arst_n        = 1'b0;
		quad_ch.valid = 1'b0;
		quad_ch.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream(1100);
		wait_results_done();
		test_backpressure();
		test_clean_tail();
		wait_results_done();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ giftag_packed_unpacker.f @@
hw/rtl/gtu_pkg.sv
hw/rtl/gtu_if.sv
hw/rtl/gtu_core.sv
hw/rtl/giftag_packed_unpacker.sv
tb/giftag_packed_unpacker_test.sv
